@@ hw/rtl/sorted_store_batch_merge_unit_macros.svh @@
// assertion macros for the sorted store batch merge unit
// expects clk and rst_n in the scope of use, no other dependencies
`ifndef SORTED_STORE_BATCH_MERGE_UNIT_MACROS_SVH
`define SORTED_STORE_BATCH_MERGE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SSBM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssbm same-cycle check failed");

// next-cycle implication, disabled during reset
`define SSBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssbm next-cycle check failed");

`endif

@@ hw/rtl/ssbm_pkg.sv @@
// shared types and constants for the sorted store batch merge unit
// no dependencies
`timescale 1ns / 1ps

package ssbm_pkg;

  // fixed field widths
  localparam int KEY_W    = 32;
  localparam int INDEX_W  = 10;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 3;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_BUFFERED    = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_MERGED      = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECT_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_READ_OK     = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_READ_RANGE  = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_BATCH_OVF   = 3'd5;

  // commands from the control to the merge core
  typedef struct packed {
    logic batch_we;
    logic merge_go;
  } ssbm_ctl_t;

  // status from the merge core
  typedef struct packed {
    logic merge_busy;
    logic merge_done;
  } ssbm_sts_t;

endpackage

@@ hw/rtl/sorted_store_batch_merge_unit.sv @@
// Sorted store with batch merge. A push with in_op low buffers one batch key
// and answers in the cycle after the transfer without raising busy. A read
// goes through the store memory read, then the registered result. The push
// marked in_batch_last merges the batch into the store from the top down;
// busy stays high through a prime step and then one store write for each
// batch key and each stored key that is greater than or equal to the smallest
// batch key, since the store memory takes one write per cycle; the result shows
// in the same cycle that busy falls. A rejected or overflowed batch answers at once.
// Each result shows on the out_ ports for exactly one cycle with out_valid
// high and cannot be held off, so it must be taken when it appears.
// No clearing pass is needed after reset: the key count bounds every read.
// Depends on ssbm_pkg, ssbm_merge and the assertion macro header.
`timescale 1ns / 1ps
`include "sorted_store_batch_merge_unit_macros.svh"

module sorted_store_batch_merge_unit #(
  parameter int STORE_DEPTH = 1024,
  parameter int BATCH_DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_op,
  input  logic signed [ssbm_pkg::KEY_W-1:0]    in_key_value,
  input  logic                                 in_batch_last,
  input  logic [ssbm_pkg::INDEX_W-1:0]         in_read_index,
  output logic                                 out_valid,
  output logic [ssbm_pkg::STATUS_W-1:0]        out_status,
  output logic signed [ssbm_pkg::KEY_W-1:0]    out_read_value,
  output logic [ssbm_pkg::COUNT_W-1:0]         out_stored_count
);

  localparam int SAW  = $clog2(STORE_DEPTH);
  localparam int BAW  = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
  localparam int SCW  = $clog2(STORE_DEPTH + 1);
  localparam int BCW  = $clog2(BATCH_DEPTH + 1);
  localparam int SUMW = ((SCW > BCW) ? SCW : BCW) + 1;
  localparam int CMPW = (ssbm_pkg::INDEX_W > SCW) ? ssbm_pkg::INDEX_W : SCW;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_MERGE = 2'd2;

  logic [1:0]                          state_r, state_nxt;
  logic [SCW-1:0]                      key_count_r, key_count_nxt;
  logic [BCW-1:0]                      batch_count_r, batch_count_nxt;
  logic                                batch_ovf_r, batch_ovf_nxt;
  logic                                idx_ok_r, idx_ok_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [ssbm_pkg::STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic signed [ssbm_pkg::KEY_W-1:0]   out_read_value_r, out_read_value_nxt;

  logic                                accept;
  logic                                room;
  logic [BCW-1:0]                      new_count;
  logic                                ovf;
  logic [SUMW-1:0]                     sum;
  logic                                fits;
  logic [CMPW-1:0]                     idx_ext;
  logic                                idx_ok;
  logic [SAW-1:0]                      read_addr;
  logic signed [ssbm_pkg::KEY_W-1:0]   read_data;
  ssbm_pkg::ssbm_ctl_t                 ctl;
  ssbm_pkg::ssbm_sts_t                 sts;
  logic                                chk_merged_res;
  logic                                chk_read_res;

  // transfer and batch bookkeeping
  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign room      = batch_count_r < BCW'(BATCH_DEPTH);
  assign new_count = room ? (batch_count_r + BCW'(1)) : batch_count_r;
  assign ovf       = batch_ovf_r || !room;
  assign sum       = SUMW'(key_count_r) + SUMW'(new_count);
  assign fits      = sum <= SUMW'(STORE_DEPTH);

  // read range check
  assign idx_ext   = CMPW'(in_read_index);
  assign idx_ok    = idx_ext < CMPW'(key_count_r);
  assign read_addr = idx_ext[SAW-1:0];

  // control sequencer
  always_comb begin
    state_nxt          = state_r;
    key_count_nxt      = key_count_r;
    batch_count_nxt    = batch_count_r;
    batch_ovf_nxt      = batch_ovf_r;
    idx_ok_nxt         = idx_ok_r;
    out_valid_nxt      = 1'b0;
    out_status_nxt     = out_status_r;
    out_read_value_nxt = out_read_value_r;
    ctl                = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == ssbm_pkg::OP_READ) begin
            idx_ok_nxt = idx_ok;
            state_nxt  = ST_READ;
          end else begin
            ctl.batch_we       = room;
            out_read_value_nxt = '0;
            if (!in_batch_last) begin
              batch_count_nxt = new_count;
              batch_ovf_nxt   = ovf;
              out_valid_nxt   = 1'b1;
              out_status_nxt  = ovf ? ssbm_pkg::STATUS_BATCH_OVF
                                    : ssbm_pkg::STATUS_BUFFERED;
            end else begin
              batch_count_nxt = '0;
              batch_ovf_nxt   = 1'b0;
              if (ovf) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ssbm_pkg::STATUS_BATCH_OVF;
              end else if (!fits) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ssbm_pkg::STATUS_REJECT_FULL;
              end else begin
                ctl.merge_go  = 1'b1;
                key_count_nxt = sum[SCW-1:0];
                state_nxt     = ST_MERGE;
              end
            end
          end
        end
      end
      ST_READ: begin
        out_valid_nxt      = 1'b1;
        out_status_nxt     = idx_ok_r ? ssbm_pkg::STATUS_READ_OK
                                      : ssbm_pkg::STATUS_READ_RANGE;
        out_read_value_nxt = idx_ok_r ? read_data : '0;
        state_nxt          = ST_IDLE;
      end
      ST_MERGE: begin
        if (sts.merge_done) begin
          out_valid_nxt      = 1'b1;
          out_status_nxt     = ssbm_pkg::STATUS_MERGED;
          out_read_value_nxt = '0;
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      key_count_r   <= '0;
      batch_count_r <= '0;
      batch_ovf_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      key_count_r   <= key_count_nxt;
      batch_count_r <= batch_count_nxt;
      batch_ovf_r   <= batch_ovf_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // result payload registers
  always_ff @(posedge clk) begin
    idx_ok_r         <= idx_ok_nxt;
    out_status_r     <= out_status_nxt;
    out_read_value_r <= out_read_value_nxt;
  end

  // memories and merge walk
  ssbm_merge #(
    .STORE_DEPTH(STORE_DEPTH),
    .BATCH_DEPTH(BATCH_DEPTH)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .batch_waddr(batch_count_r[BAW-1:0]),
    .batch_wdata(in_key_value),
    .read_addr  (read_addr),
    .merge_keys (key_count_r),
    .merge_len  (new_count),
    .read_data  (read_data),
    .sts        (sts)
  );

  // result ports
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_read_value   = out_read_value_r;
  assign out_stored_count = ssbm_pkg::COUNT_W'(key_count_r);

  // expected result shapes for the checks
  assign chk_merged_res = out_valid && (out_status == ssbm_pkg::STATUS_MERGED);
  assign chk_read_res   = out_valid && ((out_status == ssbm_pkg::STATUS_READ_OK) ||
                                        (out_status == ssbm_pkg::STATUS_READ_RANGE));

  // checks
  `SSBM_ASSERT_NOW(a_merge_core_busy, state_r == ST_MERGE, sts.merge_busy)
  `SSBM_ASSERT_NEXT(a_merge_result, sts.merge_done, chk_merged_res)
  `SSBM_ASSERT_NEXT(a_read_result, state_r == ST_READ, chk_read_res)

endmodule

@@ hw/rtl/ssbm_merge.sv @@
// merge core: holds the sorted store and batch memories and walks the
// backward merge one entry per cycle; depends on ssbm_pkg
`timescale 1ns / 1ps

module ssbm_merge #(
  parameter int STORE_DEPTH = 1024,
  parameter int BATCH_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ssbm_pkg::ssbm_ctl_t                 ctl,
  input  logic [((BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1)-1:0] batch_waddr,
  input  logic signed [ssbm_pkg::KEY_W-1:0]   batch_wdata,
  input  logic [$clog2(STORE_DEPTH)-1:0]      read_addr,
  input  logic [$clog2(STORE_DEPTH+1)-1:0]    merge_keys,
  input  logic [$clog2(BATCH_DEPTH+1)-1:0]    merge_len,
  output logic signed [ssbm_pkg::KEY_W-1:0]   read_data,
  output ssbm_pkg::ssbm_sts_t                 sts
);

  localparam int SAW = $clog2(STORE_DEPTH);
  localparam int BAW = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
  localparam int SCW = $clog2(STORE_DEPTH + 1);
  localparam int BCW = $clog2(BATCH_DEPTH + 1);

  localparam logic [1:0] M_IDLE  = 2'd0;
  localparam logic [1:0] M_PRIME = 2'd1;
  localparam logic [1:0] M_STEP  = 2'd2;

  logic [1:0]     mstate_r, mstate_nxt;
  logic [SCW-1:0] s_r, s_nxt;   // stored keys not yet placed
  logic [SCW-1:0] d_r, d_nxt;   // one above the next free slot from the top
  logic [BCW-1:0] b_r, b_nxt;   // batch keys not yet placed

  logic signed [ssbm_pkg::KEY_W-1:0] store_mem [STORE_DEPTH];
  logic signed [ssbm_pkg::KEY_W-1:0] batch_mem [BATCH_DEPTH];
  logic signed [ssbm_pkg::KEY_W-1:0] store_q_r;
  logic signed [ssbm_pkg::KEY_W-1:0] batch_q_r;

  logic [SAW-1:0]                    store_raddr;
  logic [BAW-1:0]                    batch_raddr;
  logic                              store_we;
  logic [SAW-1:0]                    store_waddr;
  logic signed [ssbm_pkg::KEY_W-1:0] store_wdata;
  logic                              take_stored;
  logic                              merge_done;
  logic [SCW-1:0]                    s_m1, s_m2, d_m1;
  logic [BCW-1:0]                    b_m1, b_m2;

  // merge sequencer: one placement per cycle, reads prefetched for the next step
  always_comb begin
    s_m1 = s_r - SCW'(1);
    s_m2 = s_r - SCW'(2);
    d_m1 = d_r - SCW'(1);
    b_m1 = b_r - BCW'(1);
    b_m2 = b_r - BCW'(2);
    take_stored = (s_r != '0) && (store_q_r >= batch_q_r);

    mstate_nxt  = mstate_r;
    s_nxt       = s_r;
    d_nxt       = d_r;
    b_nxt       = b_r;
    store_raddr = read_addr;
    batch_raddr = b_m1[BAW-1:0];
    store_we    = 1'b0;
    store_waddr = d_m1[SAW-1:0];
    store_wdata = take_stored ? store_q_r : batch_q_r;
    merge_done  = 1'b0;

    case (mstate_r)
      M_IDLE: begin
        if (ctl.merge_go) begin
          s_nxt      = merge_keys;
          d_nxt      = merge_keys + SCW'(merge_len);
          b_nxt      = merge_len;
          mstate_nxt = M_PRIME;
        end
      end
      M_PRIME: begin
        store_raddr = s_m1[SAW-1:0];
        batch_raddr = b_m1[BAW-1:0];
        mstate_nxt  = M_STEP;
      end
      M_STEP: begin
        store_we = 1'b1;
        d_nxt    = d_m1;
        if (take_stored) begin
          // stored key moves up, fetch the next stored key below it
          s_nxt       = s_m1;
          store_raddr = s_m2[SAW-1:0];
          batch_raddr = b_m1[BAW-1:0];
        end else begin
          // batch key placed, fetch the next batch key
          b_nxt       = b_m1;
          store_raddr = s_m1[SAW-1:0];
          batch_raddr = b_m2[BAW-1:0];
          if (b_r == BCW'(1)) begin
            merge_done = 1'b1;
            mstate_nxt = M_IDLE;
          end
        end
      end
      default: begin
        mstate_nxt = M_IDLE;
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mstate_r <= M_IDLE;
    end else begin
      mstate_r <= mstate_nxt;
    end
  end

  // merge pointers
  always_ff @(posedge clk) begin
    s_r <= s_nxt;
    d_r <= d_nxt;
    b_r <= b_nxt;
  end

  // sorted store memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_waddr] <= store_wdata;
    end
    store_q_r <= store_mem[store_raddr];
  end

  // batch buffer memory
  always_ff @(posedge clk) begin
    if (ctl.batch_we) begin
      batch_mem[batch_waddr] <= batch_wdata;
    end
    batch_q_r <= batch_mem[batch_raddr];
  end

  assign read_data       = store_q_r;
  assign sts.merge_done  = merge_done;
  assign sts.merge_busy  = (mstate_r != M_IDLE);

endmodule
